// ===== rtl/sdf_primitive_scene_min_macros.svh =====
// Assertion helpers shared by the RTL; each expects clock and reset in scope.
`ifndef SDF_PRIMITIVE_SCENE_MIN_MACROS_SVH
`define SDF_PRIMITIVE_SCENE_MIN_MACROS_SVH

// Same-cycle implication, held off while reset is high.
`define SPS_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sdf scene assertion failed");

// Next-cycle implication, held off while reset is high.
`define SPS_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sdf scene assertion failed");

`endif

// ===== rtl/sdfpsm_pkg.sv =====
package sdfpsm_pkg;

   localparam int WORDS_PER_ENTRY = 32;
   localparam int WORD_SEL_W      = 5;

   // transaction kinds
   localparam logic REQ_WRITE = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   // shape kinds
   localparam logic [2:0] KIND_FRACTAL = 3'd0;
   localparam logic [2:0] KIND_PLANE   = 3'd1;
   localparam logic [2:0] KIND_BOX     = 3'd2;
   localparam logic [2:0] KIND_RECT    = 3'd3;
   localparam logic [2:0] KIND_SPHERE  = 3'd4;
   localparam logic [2:0] KIND_CYL     = 3'd5;
   localparam logic [2:0] KIND_CIRCLE  = 3'd6;
   localparam logic [2:0] KIND_CONE    = 3'd7;

   // word layout of one entry
   localparam logic [4:0] W_SHAPE = 5'd0;
   localparam logic [4:0] W_POS   = 5'd1;
   localparam logic [4:0] W_MAT   = 5'd4;
   localparam logic [4:0] W_SIZE  = 5'd13;
   localparam logic [4:0] W_COLOR = 5'd17;
   localparam logic [4:0] W_REFL  = 5'd20;
   localparam logic [4:0] W_END   = 5'd21;

   typedef struct packed {
      logic               kind;
      logic [5:0]         entry_index;
      logic [4:0]         word_index;
      logic signed [31:0] word_value;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [31:0] fractal_distance;
   } req_type;

   typedef struct packed {
      logic signed [31:0] distance;
      logic [2:0]         closest_kind;
      logic [15:0]        color_red;
      logic [15:0]        color_green;
      logic [15:0]        color_blue;
      logic [16:0]        reflectance;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
      if (x > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (x < -66'sd2147483648) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

   function automatic logic [31:0] mag33(input logic signed [32:0] x);
      logic signed [32:0] n;
      n = (x < 0) ? -x : x;
      return n[31:0];
   endfunction

   // |c| - size/2, clamped to 0 .. 2^31-1
   function automatic logic [31:0] excess(input logic signed [31:0] c,
                                          input logic signed [31:0] size);
      logic signed [33:0] t;
      t = $signed({2'b00, mag33(33'(c))}) - 34'(size >>> 1);
      if (t < 0) begin
         return 32'd0;
      end else if (t > 34'sd2147483647) begin
         return 32'h7fffffff;
      end
      return t[31:0];
   endfunction

   function automatic logic [15:0] clamp16(input logic signed [31:0] w);
      if (w < 0) begin
         return 16'd0;
      end else if (w > 32'sd65535) begin
         return 16'hffff;
      end
      return w[15:0];
   endfunction

   function automatic logic [16:0] clamp17(input logic signed [31:0] w);
      if (w < 0) begin
         return 17'd0;
      end else if (w > 32'sd65536) begin
         return 17'h10000;
      end
      return w[16:0];
   endfunction

endpackage

// ===== rtl/sdfpsm_isqrt.sv =====
module sdfpsm_isqrt import sdfpsm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] x_ff;
   logic [33:0] rem_ff;
   logic [31:0] root_ff;
   logic [35:0] part;
   logic [35:0] trial;

   // one result bit per cycle, two operand bits consumed
   assign part  = {rem_ff, x_ff[63:62]};
   assign trial = {2'b00, root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            x_ff    <= value;
            rem_ff  <= '0;
            root_ff <= '0;
         end else if (busy_ff) begin
            x_ff <= {x_ff[61:0], 2'b00};
            if (part >= trial) begin
               rem_ff  <= 34'(part - trial);
               root_ff <= {root_ff[30:0], 1'b1};
            end else begin
               rem_ff  <= part[33:0];
               root_ff <= {root_ff[30:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/sdfpsm_div.sv =====
module sdfpsm_div import sdfpsm_pkg::*; #(
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [32:0] quo
);

   localparam int NUM_W = 32 + FRACTION_BITS;
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [NUM_W-1:0] quo_ff;
   logic [31:0]      den_ff;
   logic [31:0]      rem_ff;
   logic [32:0]      trial;

   // restoring division of num << FRACTION_BITS, one quotient bit per cycle
   assign trial = {rem_ff, num_ff[NUM_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            num_ff  <= {num, {FRACTION_BITS{1'b0}}};
            den_ff  <= den;
            rem_ff  <= '0;
            quo_ff  <= '0;
         end else if (busy_ff) begin
            num_ff <= {num_ff[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_ff}) begin
               rem_ff <= 32'(trial - {1'b0, den_ff});
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b1};
            end else begin
               rem_ff <= trial[31:0];
               quo_ff <= {quo_ff[NUM_W-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff[32:0];

endmodule

// ===== rtl/sdf_primitive_scene_min.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_type (table write or query point)
// rsp       out        rsp_valid/rsp_stall   rsp_type (one per query)
// csr       in         csr_we                csr_data = entries walked per query
//
// A query walks the entries in order; each is read word by word, a disabled or fractal
// entry is skipped, a plane takes the matrix pass, a sphere the squares and root pass,
// the other shapes both, and a cone with nonzero sizes also a second root pass and two divisions.
// Reset clears control only; the object table holds garbage until written.
// While a query runs the request side is stalled; a held result does not
// block the next transaction, the query only waits at its end for the slot.
`include "sdf_primitive_scene_min_macros.svh"
module sdf_primitive_scene_min import sdfpsm_pkg::*; #(
   parameter int NUM_ENTRIES   = 64,
   parameter int FRACTION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [6:0]  csr_data
);

   localparam int EIDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam int AW     = EIDX_W + WORD_SEL_W;
   localparam int DEPTH  = NUM_ENTRIES * WORDS_PER_ENTRY;
   localparam int CNT_W  = $clog2(NUM_ENTRIES + 1);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_LOAD = 4'd1;
   localparam logic [3:0] ST_MAT  = 4'd2;
   localparam logic [3:0] ST_SETV = 4'd3;
   localparam logic [3:0] ST_SQ   = 4'd4;
   localparam logic [3:0] ST_ROOT = 4'd5;
   localparam logic [3:0] ST_EVAL = 4'd6;
   localparam logic [3:0] ST_DIV  = 4'd7;
   localparam logic [3:0] ST_CMUL = 4'd8;
   localparam logic [3:0] ST_CMP  = 4'd9;
   localparam logic [3:0] ST_NEXT = 4'd10;
   localparam logic [3:0] ST_OUT  = 4'd11;

   logic [3:0]         state_ff, state_in;
   logic [6:0]         entries_ff;
   logic [CNT_W-1:0]   lim_ff, lim_in;
   logic [CNT_W-1:0]   ent_ff;
   logic [4:0]         lcnt_ff;
   logic [4:0]         cw;
   logic [4:0]         rel_i, mat_i, size_i, col_i;

   logic [31:0]        mem [DEPTH];
   logic               mem_we;
   logic [AW-1:0]      mem_wa, mem_ra;
   logic [31:0]        rd_ff;

   logic signed [31:0] p_ff [3];
   logic signed [31:0] rel_ff [3];
   logic signed [31:0] m_ff [9];
   logic signed [31:0] s_ff [4];
   logic signed [31:0] col_ff [3];
   logic signed [31:0] refl_ff;
   logic signed [31:0] q_ff [3];
   logic [2:0]         okind_ff;
   logic               oen_ff;

   logic [3:0]         mcnt_ff;
   logic [1:0]         icol_ff, irow_ff, acol_ff, arow_ff;
   logic signed [65:0] acc_ff, acc_in;

   logic [31:0]        v_ff [3];
   logic [1:0]         sq_cnt_ff;
   logic [63:0]        sum_ff;
   logic               cone_pass_ff;
   logic [31:0]        len_ff, lroot_ff;
   logic               div_sel_ff;
   logic signed [32:0] nx_ff, ny_ff;
   logic [1:0]         cm_cnt_ff;
   logic signed [35:0] t1_ff, t2;
   logic signed [35:0] d_ff;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff;

   logic               sqrt_start, sqrt_done;
   logic [63:0]        sqrt_value;
   logic [31:0]        sqrt_root;
   logic               div_start, div_done;
   logic [31:0]        div_num, div_den;
   logic [32:0]        div_quo;

   logic signed [35:0] r36, a0, hq2, cyl_d, cone_d;
   logic signed [31:0] zc, dsat;

   logic signed [31:0] best_ff;
   logic [2:0]         bkind_ff;
   logic [15:0]        bcol_ff [3];
   logic [16:0]        brefl_ff;

   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   logic               req_acc;
   logic               out_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign out_load  = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // entries walked: register value capped at table depth
   always_comb begin
      if ({25'd0, entries_ff} > 32'(NUM_ENTRIES)) begin
         lim_in = CNT_W'(NUM_ENTRIES);
      end else begin
         lim_in = CNT_W'(entries_ff);
      end
   end

   // table port: write from idle transactions, read by the walk
   assign mem_we = req_acc && (req_data.kind == REQ_WRITE)
                   && ({26'd0, req_data.entry_index} < 32'(NUM_ENTRIES));
   assign mem_wa = {EIDX_W'(req_data.entry_index), req_data.word_index};
   assign mem_ra = {ent_ff[EIDX_W-1:0], lcnt_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= req_data.word_value;
      end
      rd_ff <= mem[mem_ra];
   end

   // word captured this cycle and its offset within each group
   assign cw     = lcnt_ff - 5'd1;
   assign rel_i  = cw - W_POS;
   assign mat_i  = cw - W_MAT;
   assign size_i = cw - W_SIZE;
   assign col_i  = cw - W_COLOR;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MAT: begin
            if (mcnt_ff < 4'd9) begin
               mul_a = 33'(m_ff[mcnt_ff]);
               mul_b = 33'(rel_ff[icol_ff]);
            end
         end
         ST_SQ: begin
            if (sq_cnt_ff != 2'd3) begin
               mul_a = $signed({1'b0, v_ff[sq_cnt_ff]});
               mul_b = $signed({1'b0, v_ff[sq_cnt_ff]});
            end
         end
         ST_CMUL: begin
            if (cm_cnt_ff == 2'd0) begin
               mul_a = nx_ff;
               mul_b = $signed({1'b0, len_ff});
            end else if (cm_cnt_ff == 2'd1) begin
               mul_a = ny_ff;
               mul_b = 33'(zc);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // matrix row accumulation
   always_comb begin
      acc_in = ((acol_ff == 2'd0) ? 66'sd0 : acc_ff) + (prod_ff >>> FRACTION_BITS);
   end

   // per-kind distance terms
   assign r36    = $signed({4'b0000, sqrt_root});
   assign a0     = r36 - 36'(s_ff[0]);
   assign hq2    = $signed({4'b0000, mag33(33'(q_ff[2]))});
   assign cyl_d  = ((hq2 - 36'(s_ff[1] >>> 1)) > a0) ? (hq2 - 36'(s_ff[1] >>> 1)) : a0;
   assign zc     = sat32(66'(q_ff[2]) - 66'(s_ff[1]));
   assign t2     = 36'(prod_ff >>> FRACTION_BITS);
   assign cone_d = ((-36'(q_ff[2])) > (t1_ff + t2)) ? (-36'(q_ff[2])) : (t1_ff + t2);
   assign dsat   = sat32(66'(d_ff));

   assign sqrt_start = (state_ff == ST_SQ) && (sq_cnt_ff == 2'd3);
   assign sqrt_value = sum_ff + prod_ff[63:0];

   assign div_start = ((state_ff == ST_EVAL) && (okind_ff == KIND_CONE) && cone_pass_ff
                       && (sqrt_root != 32'd0))
                      || ((state_ff == ST_DIV) && div_done && !div_sel_ff);
   assign div_num   = (state_ff == ST_EVAL) ? mag33(33'(s_ff[1])) : mag33(33'(s_ff[0]));
   assign div_den   = (state_ff == ST_EVAL) ? sqrt_root : lroot_ff;

   sdfpsm_isqrt u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (sqrt_start),
      .value (sqrt_value),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   sdfpsm_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_data.kind == REQ_QUERY)) begin
               state_in = (lim_in == '0) ? ST_OUT : ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (lcnt_ff == W_END) begin
               if ((okind_ff == KIND_FRACTAL) || !oen_ff) begin
                  state_in = ST_NEXT;
               end else if (okind_ff == KIND_SPHERE) begin
                  state_in = ST_SETV;
               end else begin
                  state_in = ST_MAT;
               end
            end
         end
         ST_MAT: begin
            if (mcnt_ff == 4'd9) begin
               state_in = ST_SETV;
            end
         end
         ST_SETV: begin
            state_in = (okind_ff == KIND_PLANE) ? ST_CMP : ST_SQ;
         end
         ST_SQ: begin
            if (sq_cnt_ff == 2'd3) begin
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (sqrt_done) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (okind_ff != KIND_CONE) begin
               state_in = ST_CMP;
            end else if (!cone_pass_ff) begin
               state_in = ST_SETV;
            end else if (sqrt_root == 32'd0) begin
               state_in = ST_CMUL;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done && div_sel_ff) begin
               state_in = ST_CMUL;
            end
         end
         ST_CMUL: begin
            if (cm_cnt_ff == 2'd2) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            state_in = ((ent_ff + CNT_W'(1)) == lim_ff) ? ST_OUT : ST_LOAD;
         end
         ST_OUT: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         entries_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            entries_ff <= csr_data;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_data.kind == REQ_QUERY)) begin
               p_ff[0]  <= req_data.point_x;
               p_ff[1]  <= req_data.point_y;
               p_ff[2]  <= req_data.point_z;
               best_ff  <= req_data.fractal_distance;
               bkind_ff <= KIND_FRACTAL;
               bcol_ff[0] <= '0;
               bcol_ff[1] <= '0;
               bcol_ff[2] <= '0;
               brefl_ff <= '0;
               lim_ff   <= lim_in;
               ent_ff   <= '0;
               lcnt_ff  <= '0;
            end
         end
         ST_LOAD: begin
            // issue one word address per cycle, capture the previous word
            lcnt_ff <= lcnt_ff + 5'd1;
            if (lcnt_ff != 5'd0) begin
               if (cw == W_SHAPE) begin
                  okind_ff <= rd_ff[2:0];
                  oen_ff   <= rd_ff[3];
               end else if (cw < W_MAT) begin
                  rel_ff[rel_i[1:0]] <= sat32(66'(p_ff[rel_i[1:0]])
                                              - 66'($signed(rd_ff)));
               end else if (cw < W_SIZE) begin
                  m_ff[mat_i[3:0]] <= rd_ff;
               end else if (cw < W_COLOR) begin
                  s_ff[size_i[1:0]] <= rd_ff;
               end else if (cw < W_REFL) begin
                  col_ff[col_i[1:0]] <= rd_ff;
               end else begin
                  refl_ff <= rd_ff;
               end
            end
            cone_pass_ff <= 1'b0;
            mcnt_ff      <= '0;
            icol_ff      <= '0;
            irow_ff      <= '0;
         end
         ST_MAT: begin
            mcnt_ff <= mcnt_ff + 4'd1;
            acol_ff <= icol_ff;
            arow_ff <= irow_ff;
            if (icol_ff == 2'd2) begin
               icol_ff <= '0;
               irow_ff <= irow_ff + 2'd1;
            end else begin
               icol_ff <= icol_ff + 2'd1;
            end
            if (mcnt_ff != 4'd0) begin
               acc_ff <= acc_in;
               if (acol_ff == 2'd2) begin
                  q_ff[arow_ff] <= sat32(acc_in);
               end
            end
         end
         ST_SETV: begin
            sum_ff    <= '0;
            sq_cnt_ff <= '0;
            v_ff[2]   <= '0;
            case (okind_ff)
               KIND_PLANE: begin
                  d_ff <= hq2;
               end
               KIND_SPHERE: begin
                  v_ff[0] <= mag33(33'(rel_ff[0]));
                  v_ff[1] <= mag33(33'(rel_ff[1]));
                  v_ff[2] <= mag33(33'(rel_ff[2]));
               end
               KIND_BOX: begin
                  v_ff[0] <= excess(q_ff[0], s_ff[0]);
                  v_ff[1] <= excess(q_ff[1], s_ff[1]);
                  v_ff[2] <= excess(q_ff[2], s_ff[2]);
               end
               KIND_RECT: begin
                  v_ff[0] <= excess(q_ff[0], s_ff[0]);
                  v_ff[1] <= excess(q_ff[1], s_ff[1]);
                  v_ff[2] <= mag33(33'(q_ff[2]));
               end
               default: begin
                  if (cone_pass_ff) begin
                     v_ff[0] <= mag33(33'(s_ff[1]));
                     v_ff[1] <= mag33(33'(s_ff[0]));
                  end else begin
                     v_ff[0] <= mag33(33'(q_ff[0]));
                     v_ff[1] <= mag33(33'(q_ff[1]));
                  end
               end
            endcase
         end
         ST_SQ: begin
            sq_cnt_ff <= sq_cnt_ff + 2'd1;
            if (sq_cnt_ff != 2'd0) begin
               sum_ff <= sum_ff + prod_ff[63:0];
            end
         end
         ST_EVAL: begin
            div_sel_ff <= 1'b0;
            cm_cnt_ff  <= '0;
            case (okind_ff)
               KIND_SPHERE: d_ff <= a0;
               KIND_BOX:    d_ff <= r36 - 36'(s_ff[3]);
               KIND_RECT:   d_ff <= r36;
               KIND_CYL:    d_ff <= cyl_d;
               KIND_CIRCLE: d_ff <= (hq2 > a0) ? hq2 : a0;
               default: begin
                  if (!cone_pass_ff) begin
                     len_ff       <= sqrt_root;
                     cone_pass_ff <= 1'b1;
                  end else begin
                     lroot_ff <= sqrt_root;
                     nx_ff    <= 33'sd1 <<< FRACTION_BITS;
                     ny_ff    <= '0;
                  end
               end
            endcase
         end
         ST_DIV: begin
            if (div_done) begin
               if (!div_sel_ff) begin
                  nx_ff      <= $signed({1'b0, div_quo[31:0]});
                  div_sel_ff <= 1'b1;
               end else if ((s_ff[0] < 0) != (s_ff[1] < 0)) begin
                  ny_ff <= -$signed({1'b0, div_quo[31:0]});
               end else begin
                  ny_ff <= $signed({1'b0, div_quo[31:0]});
               end
            end
         end
         ST_CMUL: begin
            cm_cnt_ff <= cm_cnt_ff + 2'd1;
            if (cm_cnt_ff == 2'd1) begin
               t1_ff <= 36'(prod_ff >>> FRACTION_BITS);
            end else if (cm_cnt_ff == 2'd2) begin
               d_ff <= cone_d;
            end
         end
         ST_CMP: begin
            // strict less-than keeps the earlier entry on ties
            if (dsat < best_ff) begin
               best_ff    <= dsat;
               bkind_ff   <= okind_ff;
               bcol_ff[0] <= clamp16(col_ff[0]);
               bcol_ff[1] <= clamp16(col_ff[1]);
               bcol_ff[2] <= clamp16(col_ff[2]);
               brefl_ff   <= clamp17(refl_ff);
            end
         end
         ST_NEXT: begin
            ent_ff  <= ent_ff + CNT_W'(1);
            lcnt_ff <= '0;
         end
         ST_OUT: begin
            if (out_load) begin
               rsp_data_ff.distance     <= best_ff;
               rsp_data_ff.closest_kind <= bkind_ff;
               rsp_data_ff.color_red    <= bcol_ff[0];
               rsp_data_ff.color_green  <= bcol_ff[1];
               rsp_data_ff.color_blue   <= bcol_ff[2];
               rsp_data_ff.reflectance  <= brefl_ff;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `SPS_ASSERT_NXT(a_out_loads, out_load, rsp_valid_ff)
   `SPS_ASSERT_NXT(a_query_starts, req_acc && (req_data.kind == REQ_QUERY),
                   (state_ff == ST_LOAD) || (state_ff == ST_OUT))
   `SPS_ASSERT_IMP(a_root_in_wait, sqrt_done, state_ff == ST_ROOT)
   `SPS_ASSERT_IMP(a_div_in_wait, div_done, state_ff == ST_DIV)

endmodule
